/* design/raw_socket_wildcard_demux_unit_assert.svh */
// ----------------------------------------------------------------------------
// raw_socket_wildcard_demux_unit_assert.svh
// Assertion macros used by the checker file of the demux unit.
// ----------------------------------------------------------------------------
`ifndef RAW_SOCKET_WILDCARD_DEMUX_UNIT_ASSERT_SVH
`define RAW_SOCKET_WILDCARD_DEMUX_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while dis is true
`define RSW_ASSERT_IMPL(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("rsw assertion failed");

// Next-cycle implication, disabled while dis is true
`define RSW_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("rsw assertion failed");

`endif

/* design/rsw_pkg.sv */
// ----------------------------------------------------------------------------
// rsw_pkg
// Types and codes of the raw-socket wildcard demux unit.
// ----------------------------------------------------------------------------
package rsw_pkg;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_REG     = 2'd0,
        OP_UNREG   = 2'd1,
        OP_DELIVER = 2'd2
    } t_op;

    // Result status codes
    typedef enum logic [2:0] {
        STS_REGISTERED  = 3'd0,
        STS_INVALID_KEY = 3'd1,
        STS_TABLE_FULL  = 3'd2,
        STS_REMOVED     = 3'd3,
        STS_NOT_FOUND   = 3'd4,
        STS_DELIVERED   = 3'd5,
        STS_NO_MATCH    = 3'd6
    } t_status;

    // Match classes, searched in this order
    typedef enum logic [1:0] {
        CLS_EXACT = 2'd0,
        CLS_PROTO = 2'd1,
        CLS_ADDR  = 2'd2
    } t_class;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR = 3'd0,
        S_IDLE  = 3'd1,
        S_SCAN  = 3'd2,
        S_EVAL  = 3'd3,
        S_NEXT  = 3'd4,
        S_FINAL = 3'd5,
        S_PUSH  = 3'd6
    } t_state;

    // One binding as stored in the table memory
    typedef struct packed {
        logic        valid;
        logic [7:0]  protocol;
        logic [31:0] address;
        logic [15:0] handle;
        logic [31:0] stamp;
    } t_entry;

    // One result beat
    typedef struct packed {
        t_status     status;
        logic [15:0] handle;
        t_class      cls;
        logic        last;
    } t_result;

    // Most results one deliver item may give
    localparam logic [6:0] RESULT_CAP = 7'd64;

endpackage

/* design/rsw_mem.sv */
// ----------------------------------------------------------------------------
// rsw_mem
// Binding table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rsw_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  rsw_pkg::t_entry   i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output rsw_pkg::t_entry   o_rdata
);

    rsw_pkg::t_entry r_mem [DEPTH];
    rsw_pkg::t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/rsw_obuf.sv */
// ----------------------------------------------------------------------------
// rsw_obuf
// Output register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module rsw_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rsw_pkg::t_result  i_res,
    output logic              o_free,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output rsw_pkg::t_result  o_res
);

    logic             r_valid;
    rsw_pkg::t_result r_res;

    // slot is free when empty or draining this cycle
    assign o_free = !r_valid || !i_out_stall;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;

endmodule

/* design/rsw_ctrl.sv */
// ----------------------------------------------------------------------------
// rsw_ctrl
// Sequencer: scans the binding table, picks the newest match, updates the
// table and hands result beats to the output register.
// ----------------------------------------------------------------------------
module rsw_ctrl #(
    parameter int SOCKETS = 64,
    parameter int IW      = 6,
    parameter int CW      = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_op,
    input  logic [7:0]        i_protocol,
    input  logic [31:0]       i_address,
    input  logic [15:0]       i_socket_handle,
    // table memory
    output logic              o_we,
    output logic [IW-1:0]     o_waddr,
    output rsw_pkg::t_entry   o_wdata,
    output logic              o_re,
    output logic [IW-1:0]     o_raddr,
    input  rsw_pkg::t_entry   i_rdata,
    // output register
    output logic              o_push,
    output rsw_pkg::t_result  o_res,
    input  logic              i_free
);

    localparam logic [CW-1:0] LAST_IDX = CW'(SOCKETS - 1);
    localparam logic [CW-1:0] END_IDX  = CW'(SOCKETS);

    // single-beat result with no handle
    function automatic rsw_pkg::t_result single(input rsw_pkg::t_status st);
        rsw_pkg::t_result res;
        res.status = st;
        res.handle = 16'd0;
        res.cls    = rsw_pkg::CLS_EXACT;
        res.last   = 1'b1;
        return res;
    endfunction

    rsw_pkg::t_state  r_state, n_state;
    rsw_pkg::t_state  r_ret, n_ret;
    logic [CW-1:0]    r_idx, n_idx;
    rsw_pkg::t_op     r_op, n_op;
    logic [7:0]       r_prot, n_prot;
    logic [31:0]      r_addr, n_addr;
    logic [15:0]      r_hdl, n_hdl;
    rsw_pkg::t_class  r_class, n_class;
    logic             r_first, n_first;
    logic [31:0]      r_last_age, n_last_age;
    logic [6:0]       r_cnt, n_cnt;
    logic             r_have_held, n_have_held;
    logic [15:0]      r_held_hdl, n_held_hdl;
    rsw_pkg::t_class  r_held_cls, n_held_cls;
    rsw_pkg::t_result r_push_res, n_push_res;
    logic [31:0]      r_counter, n_counter;
    logic [CW-1:0]    r_live, n_live;

    // scan pipeline
    logic             r_pend;
    logic [IW-1:0]    r_pend_idx;
    logic             r_s_valid;
    logic             r_s_match;
    logic [31:0]      r_s_age;
    logic [IW-1:0]    r_s_idx;
    logic [15:0]      r_s_hdl;
    logic             r_found;
    logic [31:0]      r_best_age;
    logic [IW-1:0]    r_best_idx;
    logic [15:0]      r_best_hdl;

    logic             scan_start;
    logic             rd_en;
    logic [7:0]       key_prot;
    logic [31:0]      key_addr;
    logic [31:0]      rd_age;
    logic             rd_match;
    rsw_pkg::t_entry  new_entry;

    assign o_in_stall = (r_state != rsw_pkg::S_IDLE);
    assign rd_en      = (r_state == rsw_pkg::S_SCAN) && (r_idx != END_IDX);
    assign o_re       = rd_en;
    assign o_raddr    = r_idx[IW-1:0];
    assign o_res      = r_push_res;

    // key of the class being searched
    assign key_prot = (r_class == rsw_pkg::CLS_ADDR)  ? 8'd0  : r_prot;
    assign key_addr = (r_class == rsw_pkg::CLS_PROTO) ? 32'd0 : r_addr;

    // stage 1: age and match of the entry just read
    assign rd_age = r_counter - i_rdata.stamp;
    always_comb begin
        case (r_op)
            rsw_pkg::OP_REG: begin
                rd_match = !i_rdata.valid;
            end
            rsw_pkg::OP_UNREG: begin
                rd_match = i_rdata.valid && (i_rdata.protocol == r_prot) &&
                           (i_rdata.address == r_addr) && (i_rdata.handle == r_hdl);
            end
            rsw_pkg::OP_DELIVER: begin
                rd_match = i_rdata.valid && (i_rdata.protocol == key_prot) &&
                           (i_rdata.address == key_addr) &&
                           (r_first || (rd_age > r_last_age));
            end
            default: begin
                rd_match = 1'b0;
            end
        endcase
    end

    // scan pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= 1'b0;
            r_s_valid <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_pend    <= rd_en;
            r_s_valid <= r_pend;
            // stage 2: keep the first free slot, or the newest match
            if (scan_start) begin
                r_found <= 1'b0;
            end else if (r_s_valid && r_s_match &&
                         (!r_found || ((r_op != rsw_pkg::OP_REG) &&
                                       (r_s_age < r_best_age)))) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= r_idx[IW-1:0];
        r_s_match  <= rd_match;
        r_s_age    <= rd_age;
        r_s_idx    <= r_pend_idx;
        r_s_hdl    <= i_rdata.handle;
        if (r_s_valid && r_s_match &&
            (!r_found || ((r_op != rsw_pkg::OP_REG) && (r_s_age < r_best_age)))) begin
            r_best_age <= r_s_age;
            r_best_idx <= r_s_idx;
            r_best_hdl <= r_s_hdl;
        end
    end

    // entry written by a register item
    always_comb begin
        new_entry.valid    = 1'b1;
        new_entry.protocol = r_prot;
        new_entry.address  = r_addr;
        new_entry.handle   = r_hdl;
        new_entry.stamp    = r_counter;
    end

    // next state and outputs
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_idx       = r_idx;
        n_op        = r_op;
        n_prot      = r_prot;
        n_addr      = r_addr;
        n_hdl       = r_hdl;
        n_class     = r_class;
        n_first     = r_first;
        n_last_age  = r_last_age;
        n_cnt       = r_cnt;
        n_have_held = r_have_held;
        n_held_hdl  = r_held_hdl;
        n_held_cls  = r_held_cls;
        n_push_res  = r_push_res;
        n_counter   = r_counter;
        n_live      = r_live;
        scan_start  = 1'b0;
        o_we        = 1'b0;
        o_waddr     = r_best_idx;
        o_wdata     = '0;
        o_push      = 1'b0;
        case (r_state)
            // sweep invalid entries into the table after reset
            rsw_pkg::S_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_idx[IW-1:0];
                n_idx   = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = rsw_pkg::S_IDLE;
                end
            end
            // take an item
            rsw_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_op        = rsw_pkg::t_op'(i_op);
                    n_prot      = i_protocol;
                    n_addr      = i_address;
                    n_hdl       = i_socket_handle;
                    n_class     = rsw_pkg::CLS_EXACT;
                    n_first     = 1'b1;
                    n_cnt       = 7'd0;
                    n_have_held = 1'b0;
                    n_ret       = rsw_pkg::S_IDLE;
                    case (rsw_pkg::t_op'(i_op))
                        rsw_pkg::OP_REG: begin
                            if ((i_protocol == 8'd0) && (i_address == 32'd0)) begin
                                n_push_res = single(rsw_pkg::STS_INVALID_KEY);
                                n_state    = rsw_pkg::S_PUSH;
                            end else if (r_live == END_IDX) begin
                                n_push_res = single(rsw_pkg::STS_TABLE_FULL);
                                n_state    = rsw_pkg::S_PUSH;
                            end else begin
                                n_idx      = '0;
                                scan_start = 1'b1;
                                n_state    = rsw_pkg::S_SCAN;
                            end
                        end
                        rsw_pkg::OP_UNREG, rsw_pkg::OP_DELIVER: begin
                            n_idx      = '0;
                            scan_start = 1'b1;
                            n_state    = rsw_pkg::S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // one entry read per cycle, then drain the pipeline
            rsw_pkg::S_SCAN: begin
                if (r_idx != END_IDX) begin
                    n_idx = r_idx + 1'b1;
                end else if (!r_pend && !r_s_valid) begin
                    n_state = rsw_pkg::S_EVAL;
                end
            end
            // act on the scan outcome
            rsw_pkg::S_EVAL: begin
                n_ret = rsw_pkg::S_IDLE;
                case (r_op)
                    rsw_pkg::OP_REG: begin
                        o_we       = 1'b1;
                        o_wdata    = new_entry;
                        n_counter  = r_counter + 32'd1;
                        n_live     = r_live + 1'b1;
                        n_push_res = single(rsw_pkg::STS_REGISTERED);
                        n_state    = rsw_pkg::S_PUSH;
                    end
                    rsw_pkg::OP_UNREG: begin
                        if (r_found) begin
                            o_we       = 1'b1;
                            n_live     = r_live - 1'b1;
                            n_push_res = single(rsw_pkg::STS_REMOVED);
                        end else begin
                            n_push_res = single(rsw_pkg::STS_NOT_FOUND);
                        end
                        n_state = rsw_pkg::S_PUSH;
                    end
                    rsw_pkg::OP_DELIVER: begin
                        if (r_found) begin
                            // hold the new match until we know whether it is last
                            n_cnt       = r_cnt + 7'd1;
                            n_last_age  = r_best_age;
                            n_first     = 1'b0;
                            n_have_held = 1'b1;
                            n_held_hdl  = r_best_hdl;
                            n_held_cls  = r_class;
                            if (r_have_held) begin
                                n_push_res.status = rsw_pkg::STS_DELIVERED;
                                n_push_res.handle = r_held_hdl;
                                n_push_res.cls    = r_held_cls;
                                n_push_res.last   = 1'b0;
                                n_ret             = rsw_pkg::S_NEXT;
                                n_state           = rsw_pkg::S_PUSH;
                            end else begin
                                n_state = rsw_pkg::S_NEXT;
                            end
                        end else if (r_class == rsw_pkg::CLS_ADDR) begin
                            n_state = rsw_pkg::S_FINAL;
                        end else begin
                            n_class = (r_class == rsw_pkg::CLS_EXACT) ?
                                      rsw_pkg::CLS_PROTO : rsw_pkg::CLS_ADDR;
                            n_first = 1'b1;
                            n_state = rsw_pkg::S_NEXT;
                        end
                    end
                    default: begin
                        n_state = rsw_pkg::S_IDLE;
                    end
                endcase
            end
            // rescan unless the result cap is reached
            rsw_pkg::S_NEXT: begin
                if (r_cnt == rsw_pkg::RESULT_CAP) begin
                    n_state = rsw_pkg::S_FINAL;
                end else begin
                    n_idx      = '0;
                    scan_start = 1'b1;
                    n_state    = rsw_pkg::S_SCAN;
                end
            end
            // closing beat of a deliver item
            rsw_pkg::S_FINAL: begin
                if (r_have_held) begin
                    n_push_res.status = rsw_pkg::STS_DELIVERED;
                    n_push_res.handle = r_held_hdl;
                    n_push_res.cls    = r_held_cls;
                    n_push_res.last   = 1'b1;
                end else begin
                    n_push_res = single(rsw_pkg::STS_NO_MATCH);
                end
                n_ret   = rsw_pkg::S_IDLE;
                n_state = rsw_pkg::S_PUSH;
            end
            // hand a beat to the output register
            rsw_pkg::S_PUSH: begin
                if (i_free) begin
                    o_push  = 1'b1;
                    n_state = r_ret;
                end
            end
            default: begin
                n_state = rsw_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rsw_pkg::S_CLEAR;
            r_ret       <= rsw_pkg::S_IDLE;
            r_idx       <= '0;
            r_op        <= rsw_pkg::OP_REG;
            r_class     <= rsw_pkg::CLS_EXACT;
            r_first     <= 1'b1;
            r_cnt       <= 7'd0;
            r_have_held <= 1'b0;
            r_counter   <= 32'd0;
            r_live      <= '0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_idx       <= n_idx;
            r_op        <= n_op;
            r_class     <= n_class;
            r_first     <= n_first;
            r_cnt       <= n_cnt;
            r_have_held <= n_have_held;
            r_counter   <= n_counter;
            r_live      <= n_live;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_prot     <= n_prot;
        r_addr     <= n_addr;
        r_hdl      <= n_hdl;
        r_last_age <= n_last_age;
        r_held_hdl <= n_held_hdl;
        r_held_cls <= n_held_cls;
        r_push_res <= n_push_res;
    end

endmodule

/* design/raw_socket_wildcard_demux_unit.sv */
// ----------------------------------------------------------------------------
// raw_socket_wildcard_demux_unit
// Raw-socket binding table with wildcard delivery: register, unregister and
// deliver items, results in exact / protocol-only / address-only order.
// ----------------------------------------------------------------------------
// Register/unregister: table scan, evaluate, push; a rejected key or a full table
//   skips the scan and pushes its beat directly.
// Deliver: up to (matches+3) scans, each with evaluate and rescan, plus a push
//   per beat, with a cap of 64 beats per item.
// Throughput: one item at a time; next item taken once its last beat is queued.
// Reset: synchronous; clearing pass over all SOCKETS entries, input stalled until done.
module raw_socket_wildcard_demux_unit #(
    parameter int SOCKETS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_protocol,
    input  logic [31:0] i_address,
    input  logic [15:0] i_socket_handle,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_socket_handle_out,
    output logic [1:0]  o_match_class,
    output logic        o_last
);

    localparam int IW = (SOCKETS > 1) ? $clog2(SOCKETS) : 1;
    localparam int CW = $clog2(SOCKETS + 1);

    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    rsw_pkg::t_entry  mem_wdata;
    logic             mem_re;
    logic [IW-1:0]    mem_raddr;
    rsw_pkg::t_entry  mem_rdata;
    logic             push;
    rsw_pkg::t_result push_res;
    logic             free;
    rsw_pkg::t_result out_res;

    // binding table
    rsw_mem #(
        .DEPTH (SOCKETS),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // scan sequencer
    rsw_ctrl #(
        .SOCKETS (SOCKETS),
        .IW      (IW),
        .CW      (CW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_protocol      (i_protocol),
        .i_address       (i_address),
        .i_socket_handle (i_socket_handle),
        .o_we            (mem_we),
        .o_waddr         (mem_waddr),
        .o_wdata         (mem_wdata),
        .o_re            (mem_re),
        .o_raddr         (mem_raddr),
        .i_rdata         (mem_rdata),
        .o_push          (push),
        .o_res           (push_res),
        .i_free          (free)
    );

    // result register
    rsw_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_res       (push_res),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (out_res)
    );

    assign o_status            = out_res.status;
    assign o_socket_handle_out = out_res.handle;
    assign o_match_class       = out_res.cls;
    assign o_last              = out_res.last;

endmodule

/* design/rsw_chk.sv */
// ----------------------------------------------------------------------------
// rsw_chk
// Port-level checker for the demux unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "raw_socket_wildcard_demux_unit_assert.svh"

module rsw_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_op,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_status,
    input logic [15:0] o_socket_handle_out,
    input logic [1:0]  o_match_class,
    input logic        o_last
);

    logic        op_known;
    logic        in_take;
    logic        out_wait;
    logic [21:0] out_bus;

    // accepted beat carrying a defined operation
    assign op_known = (i_op == rsw_pkg::OP_REG) || (i_op == rsw_pkg::OP_UNREG) ||
                      (i_op == rsw_pkg::OP_DELIVER);
    assign in_take  = i_in_valid && !o_in_stall && op_known;

    // result beat held by the sink
    assign out_wait = o_out_valid && i_out_stall;
    assign out_bus  = {o_status, o_socket_handle_out, o_match_class, o_last};

    // reset starts the clearing pass with no beat pending
    `RSW_ASSERT_NEXT(a_reset_clear, i_clk, 1'b0, !i_rst_n, o_in_stall && !o_out_valid)

    // an accepted item with an operation keeps the input stalled while it runs
    `RSW_ASSERT_NEXT(a_busy_after_accept, i_clk, !i_rst_n, in_take, o_in_stall)

    // every non-delivery result is the only beat of its item
    `RSW_ASSERT_IMPL(a_single_last, i_clk, !i_rst_n, o_out_valid && (o_status != rsw_pkg::STS_DELIVERED), o_last)

    // a stalled result beat holds
    `RSW_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, out_wait, o_out_valid && $stable(out_bus))

endmodule

bind raw_socket_wildcard_demux_unit rsw_chk u_rsw_chk (.*);
